@@ sv/xed_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xed_pkg;

  // Hold store: the ampersand plus up to four name bytes
  localparam int unsigned HoldDepth = 5;
  // Most output bytes one item can cause: full flush plus the current byte
  localparam int unsigned MaxOut    = 6;
  localparam int unsigned EntCount  = 5;
  localparam int unsigned CountW    = 3;
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] AmpChar = 8'h26;

  // One queued run of output bytes, caused by one input item
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CountW-1:0]      count;
    logic                   last;
  } xed_entry_t;

  // Name length of an entity, semicolon included
  function automatic logic [CountW-1:0] ent_len(input logic [2:0] e);
    logic [CountW-1:0] len;
    case (e)
      3'd0:    len = 3'd3;
      3'd1:    len = 3'd3;
      3'd2:    len = 3'd4;
      3'd3:    len = 3'd5;
      3'd4:    len = 3'd5;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Name byte i of an entity (lt; gt; amp; quot; apos;)
  function automatic logic [7:0] ent_char(input logic [2:0] e, input logic [2:0] i);
    logic [7:0] ch;
    ch = 8'h00;
    case (e)
      3'd0: begin
        case (i)
          3'd0:    ch = "l";
          3'd1:    ch = "t";
          3'd2:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      3'd1: begin
        case (i)
          3'd0:    ch = "g";
          3'd1:    ch = "t";
          3'd2:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      3'd2: begin
        case (i)
          3'd0:    ch = "a";
          3'd1:    ch = "m";
          3'd2:    ch = "p";
          3'd3:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      3'd3: begin
        case (i)
          3'd0:    ch = "q";
          3'd1:    ch = "u";
          3'd2:    ch = "o";
          3'd3:    ch = "t";
          3'd4:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      3'd4: begin
        case (i)
          3'd0:    ch = "a";
          3'd1:    ch = "p";
          3'd2:    ch = "o";
          3'd3:    ch = "s";
          3'd4:    ch = ";";
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Decoded character of an entity
  function automatic logic [7:0] ent_value(input logic [2:0] e);
    logic [7:0] v;
    case (e)
      3'd0:    v = "<";
      3'd1:    v = ">";
      3'd2:    v = "&";
      3'd3:    v = 8'h22;
      3'd4:    v = 8'h27;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ sv/xed_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xed_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        in_char_i,
  input  wire logic              in_last_i,
  input  wire logic              full_i,
  output logic                   push_o,
  output xed_pkg::xed_entry_t    entry_o
);

  logic [xed_pkg::HoldDepth-1:0][7:0] held_q;
  logic [xed_pkg::CountW-1:0]         held_count_q, held_count_d;
  logic                               hold_we;
  logic [xed_pkg::CountW-1:0]         hold_idx;
  logic                               accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Classify the byte against the held prefix and build the output run
  always_comb begin
    logic [xed_pkg::CountW-1:0]         cnt;
    logic [xed_pkg::HoldDepth-1:0][7:0] cand;
    logic                               is_amp;
    logic                               pm;
    logic                               found;
    logic                               full_match;
    logic [7:0]                         dec;
    cnt = (held_count_q > 3'(xed_pkg::HoldDepth)) ? 3'(xed_pkg::HoldDepth) : held_count_q;
    is_amp = (in_char_i == xed_pkg::AmpChar);
    for (int i = 0; i < xed_pkg::HoldDepth - 1; i++) begin
      cand[i] = (3'(i + 1) < cnt) ? held_q[i+1] : in_char_i;
    end
    cand[xed_pkg::HoldDepth-1] = in_char_i;

    // First entity whose name starts with the candidate wins
    found      = 1'b0;
    full_match = 1'b0;
    dec        = 8'h00;
    for (int e = 0; e < xed_pkg::EntCount; e++) begin
      pm = (cnt <= xed_pkg::ent_len(3'(e)));
      for (int i = 0; i < xed_pkg::HoldDepth; i++) begin
        if (3'(i) < cnt && cand[i] != xed_pkg::ent_char(3'(e), 3'(i))) pm = 1'b0;
      end
      if (!found && pm) begin
        found      = 1'b1;
        full_match = (cnt == xed_pkg::ent_len(3'(e)));
        dec        = xed_pkg::ent_value(3'(e));
      end
    end

    // Default run: held bytes literally, then the current byte
    for (int i = 0; i < xed_pkg::HoldDepth; i++) begin
      entry_o.bytes[i] = (3'(i) < cnt) ? held_q[i] : in_char_i;
    end
    entry_o.bytes[xed_pkg::MaxOut-1] = in_char_i;
    entry_o.last  = in_last_i;
    entry_o.count = '0;
    held_count_d  = held_count_q;
    hold_we       = 1'b0;
    hold_idx      = '0;

    if (cnt == '0) begin
      if (is_amp && !in_last_i) begin
        hold_we      = 1'b1;
        held_count_d = 3'd1;
      end else begin
        entry_o.count = 3'd1;
      end
    end else if (found && full_match) begin
      entry_o.bytes[0] = dec;
      entry_o.count    = 3'd1;
      held_count_d     = '0;
    end else if (found && !in_last_i && cnt < 3'(xed_pkg::HoldDepth)) begin
      hold_we      = 1'b1;
      hold_idx     = cnt;
      held_count_d = 3'(cnt + 3'd1);
    end else if (found) begin
      entry_o.count = 3'(cnt + 3'd1);
      held_count_d  = '0;
    end else begin
      held_count_d = '0;
      if (is_amp && !in_last_i) begin
        entry_o.count = cnt;
        hold_we       = 1'b1;
        held_count_d  = 3'd1;
      end else begin
        entry_o.count = 3'(cnt + 3'd1);
      end
    end
  end

  assign push_o = accept && (entry_o.count != '0);

  // Advance the hold count on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= '0;
    end else if (accept) begin
      held_count_q <= held_count_d;
    end
  end

  // Store a held byte
  always_ff @(posedge clk_i) begin
    if (accept && hold_we) begin
      held_q[hold_idx] <= in_char_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/xed_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xed_queue #(
  parameter int unsigned Depth = xed_pkg::QueueDepth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire xed_pkg::xed_entry_t  push_entry_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      empty_o,
  output xed_pkg::xed_entry_t       head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xed_pkg::xed_entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = CntW'(count_q + 1'b1);
      2'b01:   count_d = CntW'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the pushed run
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/xed_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xed_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 empty_i,
  input  wire xed_pkg::xed_entry_t  head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                out_char_o,
  output logic                      out_run_end_o,
  output logic                      out_string_end_o
);

  logic [xed_pkg::CountW-1:0] idx_q, idx_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_char_q;
  logic                       run_end_q, string_end_q;
  logic                       load;
  logic                       is_end;

  assign load   = !empty_i && (!out_valid_q || out_ready_i);
  assign is_end = (idx_q == 3'(head_i.count - 3'd1));
  assign pop_o  = load && is_end;

  // Step through the head run one byte per load
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      idx_d       = is_end ? '0 : 3'(idx_q + 3'd1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q   <= head_i.bytes[idx_q];
      run_end_q    <= is_end;
      string_end_q <= is_end && head_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = out_char_q;
  assign out_run_end_o    = run_end_q;
  assign out_string_end_o = string_end_q;

endmodule

`default_nettype wire

@@ sv/xml_entity_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Predefined XML entity decoder. Text bytes enter one per item with a flag on
// the final byte; &lt; &gt; &amp; &quot; &apos; leave as their single
// character and anything else leaves literally, with run_end on the last byte
// an item causes and string_end on the last byte of the string. The front end
// accepts one item per cycle whenever the run queue (QueueDepth entries) has
// room; an accepted byte passes through the queue and then the output
// register before it shows. The output port moves one byte per cycle while
// out_ready is high, so an item that flushes a broken entity (up to six bytes)
// leaves them one after another, and a held ampersand or name byte produces
// nothing until the entity ends. No clearing pass is needed after reset.
module xml_entity_decoder #(
  parameter int unsigned QueueDepth = xed_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_run_end_o,
  output logic            out_string_end_o
);

  xed_pkg::xed_entry_t push_entry;
  xed_pkg::xed_entry_t head;
  logic                push;
  logic                full;
  logic                pop;
  logic                empty;

  xed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  xed_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  xed_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_char_o       (out_char_o),
    .out_run_end_o    (out_run_end_o),
    .out_string_end_o (out_string_end_o)
  );

endmodule

`default_nettype wire

@@ sv/xed_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xed_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_char_o,
  input wire logic       out_run_end_o,
  input wire logic       out_string_end_o
);

  // A stalled output item holds with its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(out_run_end_o) && $stable(out_string_end_o))
    else $error("output item dropped or changed while stalled");

  // The end of a string is always the end of its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_string_end_o |-> out_run_end_o)
    else $error("string_end without run_end");

  // Input back-pressure only while output is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output pending");

  // An idle output means the queue is nearly empty, so input is open next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> in_ready_o)
    else $error("input stalled right after output went idle");

endmodule

bind xml_entity_decoder xed_checker u_xed_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_char_o       (out_char_o),
  .out_run_end_o    (out_run_end_o),
  .out_string_end_o (out_string_end_o)
);

`default_nettype wire
